// File: rtl/core/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types, constants and microcode for the LFSR random draw
// Holds the LFSR step function, the control word layout and the program ROM.
// ----------------------------------------------------------------------------
package lrd_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PC_W   = 4;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned DCNT_W = 5;

	localparam logic [DATA_W-1:0] LFSR_FEEDBACK = 32'h8020_0003;
	localparam logic [DATA_W-1:0] EXTRA_SPAN    = 32'd34;

	// micro-operations driving the datapath
	localparam logic [2:0] U_IDLE  = 3'd0;
	localparam logic [2:0] U_STEP  = 3'd1;
	localparam logic [2:0] U_FOLD  = 3'd2;
	localparam logic [2:0] U_DIV   = 3'd3;
	localparam logic [2:0] U_SETN  = 3'd4;
	localparam logic [2:0] U_STEPN = 3'd5;
	localparam logic [2:0] U_DIVB  = 3'd6;
	localparam logic [2:0] U_DONE  = 3'd7;

	// sequencing modes
	localparam logic [2:0] J_NEXT      = 3'd0;
	localparam logic [2:0] J_DISPATCH  = 3'd1;
	localparam logic [2:0] J_HOLD_DIV  = 3'd2;
	localparam logic [2:0] J_HOLD_STEP = 3'd3;
	localparam logic [2:0] J_HOME      = 3'd4;

	typedef struct packed {
		logic [2:0]      uop;
		logic [2:0]      jmp;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic [2:0] uop;
	} ctrl_t;

	typedef struct packed {
		logic draw_go;
		logic div_last;
		logic step_last;
	} stat_t;

	function automatic logic [DATA_W-1:0] lfsr_advance(input logic [DATA_W-1:0] s);
		logic [DATA_W-1:0] fb;
		fb = s[0] ? LFSR_FEEDBACK : '0;
		return (s >> 1) ^ fb;
	endfunction

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = '{uop: U_IDLE,  jmp: J_DISPATCH,  target: 4'd1};
			4'd1:    w = '{uop: U_STEP,  jmp: J_NEXT,      target: 4'd0};
			4'd2:    w = '{uop: U_FOLD,  jmp: J_NEXT,      target: 4'd0};
			4'd3:    w = '{uop: U_SETN,  jmp: J_NEXT,      target: 4'd0};
			4'd4:    w = '{uop: U_STEPN, jmp: J_HOLD_STEP, target: 4'd4};
			4'd5:    w = '{uop: U_DIVB,  jmp: J_NEXT,      target: 4'd0};
			4'd6:    w = '{uop: U_DIV,   jmp: J_HOLD_DIV,  target: 4'd6};
			4'd7:    w = '{uop: U_DONE,  jmp: J_HOME,      target: 4'd0};
			default: w = '{uop: U_IDLE,  jmp: J_HOME,      target: 4'd0};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/lfsr_random_draw_top.sv
// A seed beat answers with done in the cycle after acceptance; so does a draw
// with bound 0. A nonzero draw steps the LFSR once, folds the state mod 34, steps it n
// more times (n = 1..34) and then runs the restoring bound divider before done.
// Throughput: one beat at a time; busy stays high until the draw's done cycle.
// Reset: arst_n clears the program counter, the strobe and the generator state to 0.
// The receiver cannot stall; done is high for exactly one cycle per beat.
// ----------------------------------------------------------------------------
// lfsr_random_draw_top: bounded random draws from a 32-bit Galois LFSR
// Microcoded datapath: LFSR state, mod-34 fold, restoring divider, step counter.
// ----------------------------------------------------------------------------
module lfsr_random_draw_top import lrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] value,
	output logic        done,
	output logic [31:0] random_value
);

	ctrl_t ctrl;
	stat_t stat;

	logic [DATA_W-1:0] state_q;
	logic [DATA_W-1:0] bound_q;
	logic [DATA_W-1:0] divisor_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] result_q;

	logic              accept;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic [9:0]        byte_sum;
	logic [8:0]        fold1;
	logic [7:0]        fold2;
	logic [4:0]        nib_diff;
	logic [4:0]        r17;

	assign busy   = (ctrl.uop != U_IDLE);
	assign accept = start && !busy;

	assign stat.draw_go   = accept && operation && (value != '0);
	assign stat.div_last  = (dcnt_q == '0);
	assign stat.step_last = (cnt_q == CNT_W'(1));

	lrd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// one restoring division bit per cycle
	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign diff  = trial - {1'b0, divisor_q};

	// state mod 34 = 2 * ((state >> 1) mod 17) + state[0]; 256 is 1 mod 17, so fold bytes
	assign byte_sum = 10'(state_q[8:1]) + 10'(state_q[16:9]) + 10'(state_q[24:17])
		+ 10'(state_q[31:25]);
	assign fold1    = 9'(byte_sum[7:0]) + 9'(byte_sum[9:8]);
	assign fold2    = fold1[7:0] + 8'(fold1[8]);

	// 16 is -1 mod 17: low nibble minus high nibble, wrap a negative difference
	assign nib_diff = {1'b0, rem_q[3:0]} - {1'b0, rem_q[7:4]};
	assign r17      = nib_diff[4] ? nib_diff + 5'd17 : nib_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ctrl.uop)
				U_IDLE: begin
					if (accept) begin
						done_q <= !stat.draw_go;
						if (!operation) begin
							state_q <= value;
						end
					end
				end
				U_STEP, U_STEPN: state_q <= lfsr_advance(state_q);
				U_DONE:          done_q  <= 1'b1;
				default:         state_q <= state_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.uop)
			U_IDLE: begin
				if (accept) begin
					bound_q  <= value;
					result_q <= '0;
				end
			end
			U_FOLD:  rem_q <= DATA_W'(fold2);
			U_DIVB: begin
				rem_q     <= '0;
				dvd_q     <= state_q;
				divisor_q <= bound_q;
				dcnt_q    <= '1;
			end
			U_DIV: begin
				rem_q  <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
				dvd_q  <= dvd_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			U_SETN:  cnt_q    <= {r17, state_q[0]} + 1'b1;
			U_STEPN: cnt_q    <= cnt_q - 1'b1;
			U_DONE:  result_q <= rem_q;
			default: cnt_q    <= cnt_q;
		endcase
	end

	assign done         = done_q;
	assign random_value = result_q;

`ifndef ASSERT_OFF
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(ctrl.uop) == U_DONE) || ($past(accept) && !$past(stat.draw_go)))
		else $error("done without a finished beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == U_DONE) |=> !busy && done)
		else $error("draw did not return to idle with a strobe");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == U_DIV) |-> (rem_q < divisor_q))
		else $error("partial remainder not below divisor");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == U_STEPN) |-> (cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(34)))
		else $error("step count out of range");

	a_zero_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(ctrl.uop) != U_IDLE) && ($past(state_q) == '0) |-> (state_q == '0))
		else $error("LFSR left the zero state");
`endif

endmodule

// File: rtl/core/lrd_sequencer.sv
// ----------------------------------------------------------------------------
// lrd_sequencer: microprogram counter and control ROM
// Fetches one control word per cycle and picks the next step from status.
// ----------------------------------------------------------------------------
module lrd_sequencer import lrd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	uword_t          uw;

	assign uw       = ucode_rom(pc_q);
	assign ctrl.uop = uw.uop;

	always_comb begin
		pc_next = pc_q + 1'b1;
		unique case (uw.jmp)
			J_NEXT:      pc_next = pc_q + 1'b1;
			J_DISPATCH:  pc_next = stat.draw_go ? uw.target : pc_q;
			J_HOLD_DIV:  pc_next = stat.div_last ? pc_q + 1'b1 : uw.target;
			J_HOLD_STEP: pc_next = stat.step_last ? pc_q + 1'b1 : uw.target;
			J_HOME:      pc_next = uw.target;
			default:     pc_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// File: test/lrd_draw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrd_draw_checker: prediction and scoreboard for the LFSR random draw
// Follows the command and result channels, keeps a private copy of the
// generator word, predicts every answer and compares it in order.
// ----------------------------------------------------------------------------
module lrd_draw_checker import lrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               is_draw,
	input  logic [DATA_W-1:0]  value,
	input  logic               done,
	input  logic [DATA_W-1:0]  random_value,
	output int unsigned        fail_count,
	output int unsigned        waiting
);

	logic [DATA_W-1:0] gen_word;
	logic [DATA_W-1:0] draws_due[$];

	function automatic logic [DATA_W-1:0] galois_shift(input logic [DATA_W-1:0] w);
		logic [DATA_W-1:0] tap;
		tap = w[0] ? LFSR_FEEDBACK : '0;
		return {1'b0, w[DATA_W-1:1]} ^ tap;
	endfunction

	// Updates the generator copy for a seed or a nonzero draw and returns the answer of one beat.
	function logic [DATA_W-1:0] predict_draw(input logic draw, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] w;
		int unsigned       extra;
		if (!draw) begin
			gen_word = v;
			return '0;
		end
		if (v == '0)
			return '0;
		w = galois_shift(gen_word);
		extra = (w % EXTRA_SPAN) + 1;
		repeat (extra)
			w = galois_shift(w);
		gen_word = w;
		return w % v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [DATA_W-1:0] due;
		if (!arst_n) begin
			gen_word = '0;
			draws_due.delete();
			fail_count <= 0;
			waiting <= 0;
		end else begin
			if (done) begin
				if (draws_due.size() == 0) begin
					$error("random_value: unexpected beat, got %08h", random_value);
					fail_count <= fail_count + 1;
				end else begin
					due = draws_due.pop_front();
					if (random_value !== due) begin
						$error("random_value mismatch: expected %08h, got %08h",
							due, random_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				draws_due.push_back(predict_draw(is_draw, value));
			waiting <= draws_due.size();
		end
	end

endmodule

// File: test/lfsr_random_draw_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfsr_random_draw_top_tb: testbench for the LFSR random draw block
// Directed seeds and draws at the edges of the bound, then random traffic
// with idle bursts; a separate checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module lfsr_random_draw_top_tb;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam int unsigned RANDOM_BEATS = 730;
	localparam int unsigned STEADY_TAIL  = 100;
	localparam int unsigned SETTLE       = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        operation = OP_SEED;
	logic [31:0] value = '0;
	logic        busy;
	logic        done;
	logic [31:0] random_value;
	int unsigned fail_count;
	int unsigned waiting;

	lfsr_random_draw_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.value        (value),
		.done         (done),
		.random_value (random_value)
	);

	lrd_draw_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.is_draw      (operation == OP_DRAW),
		.value        (value),
		.done         (done),
		.random_value (random_value),
		.fail_count   (fail_count),
		.waiting      (waiting)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** lfsr_random_draw_top: FAILED **");
		$finish;
	end

	// Keep start high on return so back-to-back beats need no fresh edge on it.
	task automatic issue_beat(input logic op, input logic [31:0] v);
		start <= 1'b1;
		operation <= op;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and put noise on the payload for the number of cycles given.
	task automatic hold_off(input int unsigned cycles);
		start <= 1'b0;
		operation <= 1'($urandom_range(1));
		value <= $urandom;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic drain();
		hold_off(1);
		while (waiting != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(9))
			0:       return '0;
			1, 2:    return $urandom_range(64, 1);
			3:       return 32'd1 << $urandom_range(31);
			4:       return 32'hFFFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] seed;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws before any seed must stay at zero
		issue_beat(OP_DRAW, 32'd1);
		issue_beat(OP_DRAW, 32'hFFFF_FFFF);
		issue_beat(OP_DRAW, 32'd0);
		issue_beat(OP_SEED, 32'd0);
		issue_beat(OP_DRAW, 32'd7);
		issue_beat(OP_SEED, 32'hFFFF_FFFF);
		issue_beat(OP_DRAW, 32'hFFFF_FFFF);
		issue_beat(OP_DRAW, 32'd1);
		issue_beat(OP_DRAW, 32'd0);
		issue_beat(OP_DRAW, 32'h8000_0000);
		drain();
		issue_beat(OP_SEED, 32'd1);
		issue_beat(OP_DRAW, 32'd2);
		issue_beat(OP_DRAW, 32'd34);
		issue_beat(OP_SEED, 32'h8000_0000);
		issue_beat(OP_DRAW, 32'hFFFF_FFFE);
		issue_beat(OP_SEED, 32'hA5A5_5A5A);
		issue_beat(OP_DRAW, 32'd0);
		issue_beat(OP_DRAW, 32'd0);
		issue_beat(OP_DRAW, 32'h1234_5679);
		issue_beat(OP_SEED, 32'h5A5A_A5A5);
		issue_beat(OP_DRAW, 32'd3);

		for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
			if (i < RANDOM_BEATS - STEADY_TAIL) begin
				if (i % 150 == 75)
					drain();
				else if ($urandom_range(3) == 0)
					hold_off($urandom_range(3, 1));
			end
			if ($urandom_range(6) == 0) begin
				seed = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
				issue_beat(OP_SEED, seed);
			end else begin
				issue_beat(OP_DRAW, pick_bound());
			end
		end

		drain();
		repeat (SETTLE)
			@(posedge clk);
		if (fail_count == 0 && waiting == 0)
			$display("** lfsr_random_draw_top: PASSED **");
		else
			$display("** lfsr_random_draw_top: FAILED **");
		$finish;
	end

endmodule
